// ===== sv/fnv1a_bucket_index_unit_macros.svh =====
// Assertion macros used by the hash unit controller.
`ifndef FNV1A_BUCKET_INDEX_UNIT_MACROS_SVH
`define FNV1A_BUCKET_INDEX_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled during reset.
`define FNVBI_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, disabled during reset.
`define FNVBI_ASSERT_NXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/fnvbi_pkg.sv =====
// Types and constants shared by the FNV-1a bucket index unit.
`timescale 1ns / 1ps

package fnvbi_pkg;

	localparam int HashWidth  = 64;
	localparam int CountWidth = 32;
	localparam int ByteWidth  = 8;
	localparam int DivSteps   = HashWidth;
	localparam int StepBits   = $clog2(DivSteps);

	localparam logic [HashWidth-1:0]  FnvBasis   = 64'hCBF2_9CE4_8422_2325;
	localparam logic [CountWidth-1:0] CountReset = 32'd1021;
	localparam logic [StepBits-1:0]   LastStep   = StepBits'(DivSteps - 1);

	typedef enum logic [2:0] {
		ST_ACCEPT = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic hash_upd;
		logic div_start;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

// ===== sv/fnvbi_dp.sv =====
// Datapath: running hash, constant multiply, restoring divider, output registers.
`timescale 1ns / 1ps

module fnvbi_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [fnvbi_pkg::ByteWidth-1:0]    key_byte,
	input  logic                               last_byte,
	input  logic                               bucket_count_we,
	input  logic [fnvbi_pkg::CountWidth-1:0]   bucket_count_wdata,
	input  fnvbi_pkg::cmd_t                    cmd,
	output fnvbi_pkg::status_t                 status,
	output logic [fnvbi_pkg::CountWidth-1:0]   bucket_index,
	output logic [fnvbi_pkg::HashWidth-1:0]    full_hash
);

	logic [fnvbi_pkg::HashWidth-1:0]  hash_q;
	logic [fnvbi_pkg::HashWidth-1:0]  fh_q;
	logic [fnvbi_pkg::HashWidth-1:0]  dq_q;
	logic [fnvbi_pkg::CountWidth-1:0] rem_q;
	logic [fnvbi_pkg::CountWidth-1:0] count_q;
	logic [fnvbi_pkg::StepBits-1:0]   step_q;
	logic [fnvbi_pkg::CountWidth-1:0] index_q;
	logic [fnvbi_pkg::HashWidth-1:0]  out_hash_q;

	logic [fnvbi_pkg::HashWidth-1:0]  h_mix;
	logic [fnvbi_pkg::HashWidth-1:0]  h_next;
	logic [fnvbi_pkg::CountWidth:0]   trial;
	logic [fnvbi_pkg::CountWidth:0]   diff;
	logic                             ge;
	logic [fnvbi_pkg::CountWidth-1:0] rem_next;

	// prime = 2^40 + 2^8 + 0xb3, applied as shift-adds
	assign h_mix  = hash_q ^ {{(fnvbi_pkg::HashWidth - fnvbi_pkg::ByteWidth){1'b0}}, key_byte};
	assign h_next = (h_mix << 40) + (h_mix << 8) + (h_mix << 7) + (h_mix << 5)
			+ (h_mix << 4) + (h_mix << 1) + h_mix;

	assign trial    = {rem_q, dq_q[fnvbi_pkg::HashWidth-1]};
	assign diff     = trial - {1'b0, count_q};
	assign ge       = (trial >= {1'b0, count_q});
	assign rem_next = ge ? diff[fnvbi_pkg::CountWidth-1:0] : trial[fnvbi_pkg::CountWidth-1:0];

	assign status.div_done = cmd.div_step && (step_q == fnvbi_pkg::LastStep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= fnvbi_pkg::FnvBasis;
			count_q <= fnvbi_pkg::CountReset;
			step_q  <= '0;
		end else begin
			if (bucket_count_we) begin
				count_q <= bucket_count_wdata;
			end
			if (cmd.hash_upd) begin
				hash_q <= last_byte ? fnvbi_pkg::FnvBasis : h_next;
			end
			if (cmd.div_start) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			fh_q  <= h_next;
			dq_q  <= h_next;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[fnvbi_pkg::HashWidth-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (cmd.out_load) begin
			index_q    <= (count_q == '0) ? '0 : rem_q;
			out_hash_q <= fh_q;
		end
	end

	assign bucket_index = index_q;
	assign full_hash    = out_hash_q;

endmodule

// ===== sv/fnvbi_ctrl.sv =====
// Controller: byte intake, divide sequencing and result handshake.
`timescale 1ns / 1ps
`include "fnv1a_bucket_index_unit_macros.svh"

module fnvbi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_valid,
	input  logic               last_byte,
	output logic               key_stall,
	output logic               result_valid,
	input  logic               result_stall,
	input  fnvbi_pkg::status_t status,
	output fnvbi_pkg::cmd_t    cmd
);

	fnvbi_pkg::state_t state_q;
	fnvbi_pkg::state_t state_d;
	logic              out_valid_q;
	logic              key_acc;
	logic              out_free;

	assign key_stall = (state_q != fnvbi_pkg::ST_ACCEPT);
	assign key_acc   = key_valid && !key_stall;
	assign out_free  = !out_valid_q || !result_stall;

	always_comb begin
		state_d       = state_q;
		cmd.hash_upd  = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			fnvbi_pkg::ST_ACCEPT: begin
				cmd.hash_upd  = key_acc;
				cmd.div_start = key_acc && last_byte;
				if (key_acc && last_byte) begin
					state_d = fnvbi_pkg::ST_DIVIDE;
				end
			end
			fnvbi_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = fnvbi_pkg::ST_FINISH;
				end
			end
			fnvbi_pkg::ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = fnvbi_pkg::ST_ACCEPT;
				end
			end
			default: begin
				state_d = fnvbi_pkg::ST_ACCEPT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fnvbi_pkg::ST_ACCEPT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

	`FNVBI_ASSERT_IMP(a_load_free, cmd.out_load, !out_valid_q || !result_stall, "result overwritten")
	`FNVBI_ASSERT_NXT(a_load_valid, cmd.out_load, result_valid, "loaded result not presented")
	`FNVBI_ASSERT_NXT(a_last_div, key_acc && last_byte, state_q == fnvbi_pkg::ST_DIVIDE, "divide not started")
	`FNVBI_ASSERT_NXT(a_div_end, status.div_done, state_q == fnvbi_pkg::ST_FINISH, "divide did not end")

endmodule

// ===== sv/fnv1a_bucket_index_unit.sv =====
// Top level of the FNV-1a 64-bit hash and bucket index unit.
// Non-final key bytes are taken one per cycle when not stalled; the hash update is a shift-add.
// A final byte starts a restoring divide by bucket_count, one quotient bit per cycle; its
// remainder is then registered as bucket_index, with result_valid, once the output is free.
// Bytes are stalled during the divide and until that load, which waits while a held result is stalled.
// Reset (arst_n low): running hash to the offset basis, bucket_count to 1021, no result pending.
`timescale 1ns / 1ps

module fnv1a_bucket_index_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             key_valid,
	output logic                             key_stall,
	input  logic [fnvbi_pkg::ByteWidth-1:0]  key_byte,
	input  logic                             last_byte,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [fnvbi_pkg::CountWidth-1:0] bucket_index,
	output logic [fnvbi_pkg::HashWidth-1:0]  full_hash,
	input  logic                             bucket_count_we,
	input  logic [fnvbi_pkg::CountWidth-1:0] bucket_count_wdata
);

	fnvbi_pkg::cmd_t    cmd;
	fnvbi_pkg::status_t status;

	fnvbi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_valid    (key_valid),
		.last_byte    (last_byte),
		.key_stall    (key_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	fnvbi_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.key_byte           (key_byte),
		.last_byte          (last_byte),
		.bucket_count_we    (bucket_count_we),
		.bucket_count_wdata (bucket_count_wdata),
		.cmd                (cmd),
		.status             (status),
		.bucket_index       (bucket_index),
		.full_hash          (full_hash)
	);

endmodule
